// ===== hdl/twc_pkg.sv =====
// Shared types, constants and helpers for the text window console.
package twc_pkg;

  // Screen geometry
  localparam int SCREEN_COLUMNS = 80;
  localparam int SCREEN_ROWS    = 25;
  localparam int CELL_COUNT     = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int ADDR_W         = $clog2(CELL_COUNT);

  // Field widths
  localparam int CMD_W   = 2;
  localparam int CHAR_W  = 8;
  localparam int COL_W   = 7;
  localparam int ROW_W   = 5;
  localparam int CELL_W  = 16;
  localparam int COLOR_W = 4;
  localparam int SCOL_W  = COL_W + 1;   // origin plus window column
  localparam int SROW_W  = ROW_W + 1;   // origin plus window row

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 7;

  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ORIGIN_COLUMN    = 3'd0,
    REG_ORIGIN_ROW       = 3'd1,
    REG_WINDOW_ROWS      = 3'd2,
    REG_WINDOW_COLUMNS   = 3'd3,
    REG_BACKGROUND_COLOR = 3'd4,
    REG_FOREGROUND_COLOR = 3'd5
  } cfg_index_t;

  typedef struct packed {
    logic [COL_W-1:0]   origin_column;
    logic [ROW_W-1:0]   origin_row;
    logic [ROW_W-1:0]   window_rows;
    logic [COL_W-1:0]   window_columns;
    logic [COLOR_W-1:0] background_color;
    logic [COLOR_W-1:0] foreground_color;
  } twc_cfg_t;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    DP_NOP,
    DP_LATCH,
    DP_SWEEP,
    DP_PUT,
    DP_NEWLINE,
    DP_RETURN,
    DP_READ,
    DP_WRAP,
    DP_SCR_START,
    DP_SCR_RD,
    DP_SCR_WR,
    DP_FILL,
    DP_CLEAR_START,
    DP_CLEAR_CELL,
    DP_RESULT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } twc_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic             is_newline;
    logic             is_return;
    logic             sweep_last;
    logic             x_wrap;
    logic             y_over;
    logic             scr_done;
    logic             col_last;
    logic             row_last;
    logic             out_free;
  } twc_status_t;

  function automatic logic [CELL_W-1:0] make_cell(input logic [COLOR_W-1:0] bg,
                                                  input logic [COLOR_W-1:0] fg,
                                                  input logic [CHAR_W-1:0]  ch);
    make_cell = {bg, fg, ch};
  endfunction

  function automatic logic in_screen(input logic [SCOL_W-1:0] col,
                                     input logic [SROW_W-1:0] row);
    in_screen = (int'(col) < SCREEN_COLUMNS) && (int'(row) < SCREEN_ROWS);
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [SCOL_W-1:0] col,
                                                  input logic [SROW_W-1:0] row);
    cell_addr = ADDR_W'(int'(row) * SCREEN_COLUMNS + int'(col));
  endfunction

endpackage

// ===== hdl/twc_cfg.sv =====
// Configuration register file of the text window console.
module twc_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [twc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [twc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output twc_pkg::twc_cfg_t              cfg
);
  import twc_pkg::*;

  twc_cfg_t cfg_r;

  // Decode the register index and take the write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_column    <= '0;
      cfg_r.origin_row       <= '0;
      cfg_r.window_rows      <= ROW_W'(25);
      cfg_r.window_columns   <= COL_W'(80);
      cfg_r.background_color <= '0;
      cfg_r.foreground_color <= COLOR_W'(15);
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        REG_ORIGIN_COLUMN:    cfg_r.origin_column    <= cfg_wdata[COL_W-1:0];
        REG_ORIGIN_ROW:       cfg_r.origin_row       <= cfg_wdata[ROW_W-1:0];
        REG_WINDOW_ROWS:      cfg_r.window_rows      <= cfg_wdata[ROW_W-1:0];
        REG_WINDOW_COLUMNS:   cfg_r.window_columns   <= cfg_wdata[COL_W-1:0];
        REG_BACKGROUND_COLOR: cfg_r.background_color <= cfg_wdata[COLOR_W-1:0];
        REG_FOREGROUND_COLOR: cfg_r.foreground_color <= cfg_wdata[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hdl/twc_dp.sv =====
// Datapath: screen store, cursor, walk counters and result register.
module twc_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  twc_pkg::twc_cfg_t           cfg,
  input  twc_pkg::twc_cmd_t           cmd,
  output twc_pkg::twc_status_t        status,
  input  logic [twc_pkg::CMD_W-1:0]   in_command,
  input  logic [twc_pkg::CHAR_W-1:0]  in_character,
  input  logic [twc_pkg::COL_W-1:0]   in_read_column,
  input  logic [twc_pkg::ROW_W-1:0]   in_read_row,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [twc_pkg::CELL_W-1:0]  out_cell_value,
  output logic [twc_pkg::COL_W-1:0]   out_cursor_column,
  output logic [twc_pkg::ROW_W-1:0]   out_cursor_row
);
  import twc_pkg::*;

  // Screen store
  logic [CELL_W-1:0] mem [CELL_COUNT];
  logic [CELL_W-1:0] mem_q_r;

  // Latched item
  logic [CMD_W-1:0]  command_r;
  logic [CHAR_W-1:0] char_r;
  logic [COL_W-1:0]  rcol_r;
  logic [ROW_W-1:0]  rrow_r;

  // Cursor, walk counters, sweep counter and flags
  logic [COL_W-1:0]  x_r, x_nxt;
  logic [ROW_W-1:0]  y_r, y_nxt;
  logic [COL_W-1:0]  c_r, c_nxt;
  logic [ROW_W-1:0]  r_r, r_nxt;
  logic [ADDR_W-1:0] sweep_r;
  logic              read_hit_r;
  logic              src_hit_r;

  // Result register
  logic              out_valid_r;
  logic [CELL_W-1:0] out_cell_r;
  logic [COL_W-1:0]  out_col_r;
  logic [ROW_W-1:0]  out_row_r;

  logic [ROW_W-1:0]  rows_eff;
  logic [COL_W-1:0]  cols_eff;
  logic [COL_W-1:0]  wcol;
  logic [ROW_W-1:0]  wrow;
  logic [SCOL_W-1:0] scol;
  logic [SROW_W-1:0] srow;
  logic [SCOL_W-1:0] rd_col;
  logic [SROW_W-1:0] rd_row;
  logic              wr_hit;
  logic              rd_hit;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [CELL_W-1:0] wdata;
  logic              re;
  logic              col_last;
  logic              row_last;
  logic              result_load;

  // Treat a zero window size as one
  assign rows_eff = (cfg.window_rows == '0) ? ROW_W'(1) : cfg.window_rows;
  assign cols_eff = (cfg.window_columns == '0) ? COL_W'(1) : cfg.window_columns;

  assign col_last = c_r >= (cols_eff - COL_W'(1));
  assign row_last = r_r >= (rows_eff - ROW_W'(1));

  // Pick the window cell for this operation and place it on the screen
  always_comb begin
    wcol = (cmd.op == DP_PUT) ? x_r : c_r;
    case (cmd.op)
      DP_PUT:    wrow = y_r;
      DP_SCR_WR: wrow = r_r - ROW_W'(1);
      DP_FILL:   wrow = rows_eff - ROW_W'(1);
      default:   wrow = r_r;
    endcase
    scol = SCOL_W'(cfg.origin_column) + SCOL_W'(wcol);
    srow = SROW_W'(cfg.origin_row) + SROW_W'(wrow);
    if (cmd.op == DP_READ) begin
      rd_col = SCOL_W'(rcol_r);
      rd_row = SROW_W'(rrow_r);
    end else begin
      rd_col = scol;
      rd_row = srow;
    end
    wr_hit = in_screen(scol, srow);
    rd_hit = in_screen(rd_col, rd_row);
  end

  // Write port selection
  always_comb begin
    we    = 1'b0;
    waddr = cell_addr(scol, srow);
    wdata = make_cell(cfg.background_color, cfg.foreground_color, '0);
    case (cmd.op)
      DP_SWEEP: begin
        we    = 1'b1;
        waddr = sweep_r;
        wdata = '0;
      end
      DP_PUT: begin
        we    = wr_hit;
        wdata = make_cell(cfg.background_color, cfg.foreground_color, char_r);
      end
      DP_SCR_WR: begin
        we    = wr_hit;
        wdata = src_hit_r ? mem_q_r : '0;
      end
      DP_FILL, DP_CLEAR_CELL: begin
        we = wr_hit;
      end
      default: ;
    endcase
    re = ((cmd.op == DP_READ) || (cmd.op == DP_SCR_RD)) && rd_hit;
  end

  // Screen store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      mem_q_r <= mem[cell_addr(rd_col, rd_row)];
    end
  end

  // Next cursor and walk counter values
  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    c_nxt = c_r;
    r_nxt = r_r;
    case (cmd.op)
      DP_NEWLINE, DP_WRAP: begin
        x_nxt = '0;
        y_nxt = y_r + ROW_W'(1);
      end
      DP_RETURN: x_nxt = '0;
      DP_PUT:    x_nxt = x_r + COL_W'(1);
      DP_SCR_START: begin
        c_nxt = '0;
        r_nxt = ROW_W'(1);
      end
      DP_CLEAR_START: begin
        c_nxt = '0;
        r_nxt = '0;
      end
      DP_SCR_WR, DP_CLEAR_CELL: begin
        if (col_last) begin
          c_nxt = '0;
          r_nxt = r_r + ROW_W'(1);
        end else begin
          c_nxt = c_r + COL_W'(1);
        end
        if ((cmd.op == DP_CLEAR_CELL) && col_last && row_last) begin
          x_nxt = '0;
          y_nxt = '0;
        end
      end
      DP_FILL: begin
        if (col_last) begin
          c_nxt = '0;
          y_nxt = y_r - ROW_W'(1);
        end else begin
          c_nxt = c_r + COL_W'(1);
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r         <= '0;
      y_r         <= '0;
      c_r         <= '0;
      r_r         <= '0;
      sweep_r     <= '0;
      read_hit_r  <= 1'b0;
      src_hit_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      c_r <= c_nxt;
      r_r <= r_nxt;
      if (cmd.op == DP_SWEEP) begin
        sweep_r <= sweep_r + ADDR_W'(1);
      end
      if (cmd.op == DP_LATCH) begin
        read_hit_r <= 1'b0;
      end else if (cmd.op == DP_READ) begin
        read_hit_r <= rd_hit;
      end
      if (cmd.op == DP_SCR_RD) begin
        src_hit_r <= rd_hit;
      end
      if (result_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold the item and the result payload
  assign result_load = (cmd.op == DP_RESULT);

  always_ff @(posedge clk) begin
    if (cmd.op == DP_LATCH) begin
      command_r <= in_command;
      char_r    <= in_character;
      rcol_r    <= in_read_column;
      rrow_r    <= in_read_row;
    end
    if (result_load) begin
      out_cell_r <= read_hit_r ? mem_q_r : '0;
      out_col_r  <= x_r;
      out_row_r  <= y_r;
    end
  end

  // Status towards the controller
  always_comb begin
    status.command    = command_r;
    status.is_newline = (char_r == CH_NEWLINE);
    status.is_return  = (char_r == CH_RETURN);
    status.sweep_last = (int'(sweep_r) == CELL_COUNT - 1);
    status.x_wrap     = x_r >= cols_eff;
    status.y_over     = y_r >= rows_eff;
    status.scr_done   = r_r >= rows_eff;
    status.col_last   = col_last;
    status.row_last   = row_last;
    status.out_free   = !out_valid_r || out_ready;
  end

  assign out_valid         = out_valid_r;
  assign out_cell_value    = out_cell_r;
  assign out_cursor_column = out_col_r;
  assign out_cursor_row    = out_row_r;

endmodule

// ===== hdl/twc_ctrl.sv =====
// Controller state machine sequencing the console datapath.
module twc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  twc_pkg::twc_status_t status,
  output twc_pkg::twc_cmd_t    cmd
);
  import twc_pkg::*;

  typedef enum logic [8:0] {
    S_INIT   = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_DECODE = 9'b000000100,
    S_SETTLE = 9'b000001000,
    S_SCR_RD = 9'b000010000,
    S_SCR_WR = 9'b000100000,
    S_FILL   = 9'b001000000,
    S_CLEAR  = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // Next state and datapath operation
  always_comb begin
    state_nxt = state_r;
    cmd.op    = DP_NOP;
    unique case (state_r)
      S_INIT: begin
        cmd.op = DP_SWEEP;
        if (status.sweep_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = DP_LATCH;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (status.command)
          CMD_PUT: begin
            if (status.is_newline) begin
              cmd.op    = DP_NEWLINE;
              state_nxt = S_SETTLE;
            end else if (status.is_return) begin
              cmd.op    = DP_RETURN;
              state_nxt = S_DONE;
            end else begin
              cmd.op    = DP_PUT;
              state_nxt = S_SETTLE;
            end
          end
          CMD_READ: begin
            cmd.op    = DP_READ;
            state_nxt = S_DONE;
          end
          CMD_CLEAR: begin
            cmd.op    = DP_CLEAR_START;
            state_nxt = S_CLEAR;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_SETTLE: begin
        if (status.x_wrap) begin
          cmd.op = DP_WRAP;
        end else if (status.y_over) begin
          cmd.op    = DP_SCR_START;
          state_nxt = S_SCR_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SCR_RD: begin
        if (status.scr_done) begin
          state_nxt = S_FILL;
        end else begin
          cmd.op    = DP_SCR_RD;
          state_nxt = S_SCR_WR;
        end
      end
      S_SCR_WR: begin
        cmd.op    = DP_SCR_WR;
        state_nxt = S_SCR_RD;
      end
      S_FILL: begin
        cmd.op = DP_FILL;
        if (status.col_last) begin
          state_nxt = S_SETTLE;
        end
      end
      S_CLEAR: begin
        cmd.op = DP_CLEAR_CELL;
        if (status.col_last && status.row_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.op    = DP_RESULT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

endmodule

// ===== hdl/text_window_console_unit.sv =====
// Top level of the text window console: config, controller and datapath.
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid / in_ready     | command, character, read column/row
//   out     | output    | out_valid / out_ready   | cell value, cursor column/row
//   cfg     | input     | cfg_we (no wait)        | cfg_index, cfg_wdata
//
// A plain put or a newline goes through decode, settle and done before the next acceptance;
// a carriage return, a read or an unused command skips settle; a put that wraps adds a wrap step.
// A scroll reads each moved cell and then writes it, then fills the bottom row;
// a clear writes each window cell in turn, then finishes as a read does.
// After reset the store is zeroed one cell a cycle, all 2000 cells with in_ready low.
// A finished result waits in the output register while the next item is accepted.
module text_window_console_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [twc_pkg::CMD_W-1:0]       in_command,
  input  logic [twc_pkg::CHAR_W-1:0]      in_character,
  input  logic [twc_pkg::COL_W-1:0]       in_read_column,
  input  logic [twc_pkg::ROW_W-1:0]       in_read_row,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [twc_pkg::CELL_W-1:0]      out_cell_value,
  output logic [twc_pkg::COL_W-1:0]       out_cursor_column,
  output logic [twc_pkg::ROW_W-1:0]       out_cursor_row,
  input  logic                            cfg_we,
  input  logic [twc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [twc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import twc_pkg::*;

  twc_cfg_t    cfg;
  twc_cmd_t    dp_cmd;
  twc_status_t dp_status;

  twc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  twc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (dp_status),
    .cmd      (dp_cmd)
  );

  twc_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .cmd               (dp_cmd),
    .status            (dp_status),
    .in_command        (in_command),
    .in_character      (in_character),
    .in_read_column    (in_read_column),
    .in_read_row       (in_read_row),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_cell_value    (out_cell_value),
    .out_cursor_column (out_cursor_column),
    .out_cursor_row    (out_cursor_row)
  );

  // One item at a time: ready drops after an item is taken
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("item accepted while another is in progress");

  // Never overwrite a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (dp_cmd.op == DP_RESULT) |-> (!out_valid || out_ready))
    else $error("result register overwritten before it was taken");

  // No item is taken while the store is being zeroed
  a_sweep_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (dp_cmd.op == DP_SWEEP) |-> !in_ready)
    else $error("input ready during the store clearing pass");

  // A load of the result register makes it valid in the next cycle
  a_result_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (dp_cmd.op == DP_RESULT) |=> out_valid)
    else $error("result load did not raise out_valid");

endmodule

// ===== tb/tb_text_window_console_unit.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the text window console: puts, reads, clears, scrolls.
module tb_text_window_console_unit;
  import twc_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED   = 2'd3;
  localparam int               STALL_LIMIT  = 400000;
  localparam int               TAIL_CYCLES  = 16;
  localparam int               SEGMENTS     = 21;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [CHAR_W-1:0] character;
    logic [COL_W-1:0]  read_column;
    logic [ROW_W-1:0]  read_row;
  } console_item_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_value;
    logic [COL_W-1:0]  cursor_column;
    logic [ROW_W-1:0]  cursor_row;
  } console_view_t;

  logic                   clk;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [CMD_W-1:0]       in_command = '0;
  logic [CHAR_W-1:0]      in_character = '0;
  logic [COL_W-1:0]       in_read_column = '0;
  logic [ROW_W-1:0]       in_read_row = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [CELL_W-1:0]      out_cell_value;
  logic [COL_W-1:0]       out_cursor_column;
  logic [ROW_W-1:0]       out_cursor_row;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  // Shadow of the screen, the cursor and the window registers
  logic [CELL_W-1:0]  screen_image [CELL_COUNT];
  int unsigned        cursor_col = 0;
  int unsigned        cursor_line = 0;
  logic [COL_W-1:0]   win_origin_col = '0;
  logic [ROW_W-1:0]   win_origin_row = '0;
  logic [ROW_W-1:0]   win_rows = 5'd25;
  logic [COL_W-1:0]   win_cols = 7'd80;
  logic [COLOR_W-1:0] paint_bg = 4'h0;
  logic [COLOR_W-1:0] paint_fg = 4'hF;

  console_item_t pending_items [$];
  console_view_t expected_views [$];
  int            fail_count = 0;
  int            stall_cycles = 0;
  int            sender_idle_pct = 38;
  int            receiver_idle_pct = 61;

  text_window_console_unit DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_character      (in_character),
    .in_read_column    (in_read_column),
    .in_read_row       (in_read_row),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_cell_value    (out_cell_value),
    .out_cursor_column (out_cursor_column),
    .out_cursor_row    (out_cursor_row),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // A window size of zero behaves as one
  function automatic int unsigned rows_in_use();
    return (win_rows == '0) ? 1 : int'(win_rows);
  endfunction

  function automatic int unsigned cols_in_use();
    return (win_cols == '0) ? 1 : int'(win_cols);
  endfunction

  // Cells off the screen read as zero and swallow writes
  function automatic logic [CELL_W-1:0] peek_cell(input int unsigned col,
                                                  input int unsigned row);
    if (col >= SCREEN_COLUMNS || row >= SCREEN_ROWS) return '0;
    return screen_image[row * SCREEN_COLUMNS + col];
  endfunction

  task automatic poke_cell(input int unsigned col, input int unsigned row,
                           input logic [CELL_W-1:0] word);
    if (col < SCREEN_COLUMNS && row < SCREEN_ROWS)
      screen_image[row * SCREEN_COLUMNS + col] = word;
  endtask

  // Shift the window up one row, top row first, and blank the bottom row
  task automatic scroll_window();
    int unsigned rows;
    int unsigned cols;
    rows = rows_in_use();
    cols = cols_in_use();
    for (int unsigned r = 1; r < rows; r++)
      for (int unsigned c = 0; c < cols; c++)
        poke_cell(win_origin_col + c, win_origin_row + r - 1,
                  peek_cell(win_origin_col + c, win_origin_row + r));
    for (int unsigned c = 0; c < cols; c++)
      poke_cell(win_origin_col + c, win_origin_row + rows - 1, {paint_bg, paint_fg, 8'h00});
  endtask

  // Wrap at the window width, then scroll once per row below the window
  task automatic wrap_and_scroll();
    if (cursor_col >= cols_in_use()) begin
      cursor_line++;
      cursor_col = 0;
    end
    while (cursor_line >= rows_in_use()) begin
      scroll_window();
      cursor_line--;
    end
  endtask

  task automatic console_step(input console_item_t work, output console_view_t view);
    logic [CELL_W-1:0] cell_word;
    cell_word = '0;
    case (work.command)
      CMD_PUT: begin
        if (work.character == CH_NEWLINE) begin
          cursor_line++;
          cursor_col = 0;
          wrap_and_scroll();
        end else if (work.character == CH_RETURN) begin
          cursor_col = 0;
        end else begin
          poke_cell(win_origin_col + cursor_col, win_origin_row + cursor_line,
                    {paint_bg, paint_fg, work.character});
          cursor_col++;
          wrap_and_scroll();
        end
      end
      CMD_READ: begin
        cell_word = peek_cell(work.read_column, work.read_row);
      end
      CMD_CLEAR: begin
        for (int unsigned r = 0; r < rows_in_use(); r++)
          for (int unsigned c = 0; c < cols_in_use(); c++)
            poke_cell(win_origin_col + c, win_origin_row + r, {paint_bg, paint_fg, 8'h00});
        cursor_col = 0;
        cursor_line = 0;
      end
      default: begin
      end
    endcase
    view.cell_value    = cell_word;
    view.cursor_column = COL_W'(cursor_col);
    view.cursor_row    = ROW_W'(cursor_line);
  endtask

  // Driver: predict each accepted item, then offer the next one or idle
  always @(posedge clk) begin
    console_item_t accepted;
    console_item_t next_item;
    console_view_t view;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        accepted.command     = in_command;
        accepted.character   = in_character;
        accepted.read_column = in_read_column;
        accepted.read_row    = in_read_row;
        console_step(accepted, view);
        expected_views.push_back(view);
      end
      if (!in_valid || in_ready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          next_item = pending_items.pop_front();
          in_valid       <= 1'b1;
          in_command     <= next_item.command;
          in_character   <= next_item.character;
          in_read_column <= next_item.read_column;
          in_read_row    <= next_item.read_row;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    console_view_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_views.size() == 0) begin
          $error("result with no item outstanding: cell_value %h", out_cell_value);
          fail_count++;
        end else begin
          want = expected_views.pop_front();
          if (out_cell_value !== want.cell_value) begin
            $error("cell_value: expected %h, got %h", want.cell_value, out_cell_value);
            fail_count++;
          end
          if (out_cursor_column !== want.cursor_column) begin
            $error("cursor_column: expected %0d, got %0d",
                   want.cursor_column, out_cursor_column);
            fail_count++;
          end
          if (out_cursor_row !== want.cursor_row) begin
            $error("cursor_row: expected %0d, got %0d", want.cursor_row, out_cursor_row);
            fail_count++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  // Watchdog: give up after a long stretch with no item moving either way
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic queue_item(input logic [CMD_W-1:0] command, input logic [CHAR_W-1:0] ch,
                            input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row);
    console_item_t work;
    work.command     = command;
    work.character   = ch;
    work.read_column = col;
    work.read_row    = row;
    pending_items.push_back(work);
  endtask

  // Hold until every item is in, every result is out and the block is ready
  task automatic wait_until_drained();
    do @(posedge clk);
    while (pending_items.size() != 0 || in_valid || expected_views.size() != 0 || !in_ready);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input cfg_index_t reg_index,
                                input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= reg_index;
    cfg_wdata <= data;
    case (reg_index)
      REG_ORIGIN_COLUMN:    win_origin_col = data[COL_W-1:0];
      REG_ORIGIN_ROW:       win_origin_row = data[ROW_W-1:0];
      REG_WINDOW_ROWS:      win_rows = data[ROW_W-1:0];
      REG_WINDOW_COLUMNS:   win_cols = data[COL_W-1:0];
      REG_BACKGROUND_COLOR: paint_bg = data[COLOR_W-1:0];
      REG_FOREGROUND_COLOR: paint_fg = data[COLOR_W-1:0];
      default: begin
      end
    endcase
  endtask

  task automatic program_window(input logic [COL_W-1:0] col0, input logic [ROW_W-1:0] row0,
                                input logic [ROW_W-1:0] rows, input logic [COL_W-1:0] cols,
                                input logic [COLOR_W-1:0] bg, input logic [COLOR_W-1:0] fg);
    wait_until_drained();
    write_register(REG_ORIGIN_COLUMN, CFG_DATA_W'(col0));
    write_register(REG_ORIGIN_ROW, CFG_DATA_W'(row0));
    write_register(REG_WINDOW_ROWS, CFG_DATA_W'(rows));
    write_register(REG_WINDOW_COLUMNS, CFG_DATA_W'(cols));
    write_register(REG_BACKGROUND_COLOR, CFG_DATA_W'(bg));
    write_register(REG_FOREGROUND_COLOR, CFG_DATA_W'(fg));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly small windows; a roomy one may span the whole register range
  task automatic program_random_window(input bit roomy);
    logic [COL_W-1:0] col0;
    logic [ROW_W-1:0] row0;
    logic [ROW_W-1:0] rows;
    logic [COL_W-1:0] cols;
    if (roomy) begin
      col0 = $urandom_range(1) ? COL_W'($urandom_range(127)) : '0;
      row0 = $urandom_range(1) ? ROW_W'($urandom_range(31)) : '0;
      rows = ROW_W'($urandom_range(31));
      cols = COL_W'($urandom_range(127));
    end else begin
      col0 = ($urandom_range(9) < 7) ? COL_W'($urandom_range(79)) : COL_W'($urandom_range(127));
      row0 = ($urandom_range(9) < 7) ? ROW_W'($urandom_range(24)) : ROW_W'($urandom_range(31));
      rows = ROW_W'($urandom_range(6));
      cols = COL_W'($urandom_range(12));
    end
    program_window(col0, row0, rows, cols, COLOR_W'($urandom_range(15)),
                   COLOR_W'($urandom_range(15)));
  endtask

  // Mostly puts with plenty of newlines, so windows fill and scroll
  task automatic queue_random_items(input int count);
    int            pick;
    console_item_t work;
    repeat (count) begin
      pick             = $urandom_range(99);
      work.command     = CMD_PUT;
      work.character   = CHAR_W'($urandom_range(255));
      work.read_column = COL_W'($urandom_range(127));
      work.read_row    = ROW_W'($urandom_range(31));
      if (pick < 55) begin
      end else if (pick < 67) begin
        work.character = CH_NEWLINE;
      end else if (pick < 71) begin
        work.character = CH_RETURN;
      end else if (pick < 91) begin
        work.command = CMD_READ;
        if ($urandom_range(3) != 0) begin
          work.read_column = COL_W'(win_origin_col + $urandom_range(cols_in_use() - 1));
          work.read_row    = ROW_W'(win_origin_row + $urandom_range(rows_in_use() - 1));
        end
      end else if (pick < 95) begin
        work.command = CMD_CLEAR;
      end else begin
        work.command = CMD_UNUSED;
      end
      pending_items.push_back(work);
    end
  endtask

  initial begin
    bit roomy;
    foreach (screen_image[i]) screen_image[i] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Full-screen window after reset: extreme bytes, return, newline, reads
    queue_item(CMD_PUT, 8'h48, 7'd0, 5'd0);
    queue_item(CMD_PUT, 8'hFF, 7'd127, 5'd31);
    queue_item(CMD_PUT, 8'h00, 7'd0, 5'd0);
    queue_item(CMD_PUT, CH_RETURN, 7'd0, 5'd0);
    queue_item(CMD_PUT, CH_NEWLINE, 7'd0, 5'd0);
    queue_item(CMD_READ, 8'h00, 7'd0, 5'd0);
    queue_item(CMD_READ, 8'hFF, 7'd1, 5'd0);
    queue_item(CMD_READ, 8'h00, 7'd79, 5'd24);
    queue_item(CMD_READ, 8'h00, 7'd127, 5'd31);
    queue_item(CMD_UNUSED, 8'hA5, 7'h55, 5'h15);

    // Window hanging off the bottom-right corner: dropped writes, scroll reads zero
    program_window(7'd78, 5'd23, 5'd3, 7'd4, 4'hF, 4'h0);
    queue_item(CMD_CLEAR, 8'h00, 7'd0, 5'd0);
    for (int k = 0; k < 5; k++) queue_item(CMD_PUT, CHAR_W'(8'h61 + k), 7'd0, 5'd0);
    queue_item(CMD_PUT, CH_NEWLINE, 7'd0, 5'd0);
    queue_item(CMD_PUT, CH_NEWLINE, 7'd0, 5'd0);
    queue_item(CMD_READ, 8'h00, 7'd78, 5'd23);
    queue_item(CMD_READ, 8'h00, 7'd79, 5'd24);

    // Zero-sized window with the cursor left below it: several scrolls in one put
    program_window(7'd0, 5'd0, 5'd0, 7'd0, 4'h5, 4'hA);
    queue_item(CMD_PUT, 8'h78, 7'd0, 5'd0);
    queue_item(CMD_PUT, CH_RETURN, 7'd0, 5'd0);
    queue_item(CMD_READ, 8'h00, 7'd0, 5'd0);

    // Largest register values
    program_window(7'd0, 5'd0, 5'd31, 7'd127, 4'h0, 4'hF);
    queue_item(CMD_CLEAR, 8'h00, 7'd0, 5'd0);
    queue_item(CMD_PUT, 8'h5A, 7'd0, 5'd0);
    queue_item(CMD_READ, 8'h00, 7'd0, 5'd0);

    // Random windows; swap the idling sides, then run flat out
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      roomy = (seg % 6 == 3);
      program_random_window(roomy);
      if (seg == 7) begin
        sender_idle_pct   = 61;
        receiver_idle_pct = 38;
      end else if (seg == 14) begin
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
      end
      queue_random_items(roomy ? 10 : 28);
    end

    wait_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_views.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
